/* design/ppa_pkg.sv */
// ----------------------------------------------------------------------------
// Playback position advance package
// Shared widths, register indexes, operation codes and the status flag type.
// ----------------------------------------------------------------------------
package ppa_pkg;

   localparam int TIME_W     = 32;
   localparam int LOOP_W     = 16;
   localparam int SPEED_W    = 16;
   localparam int SPEED_FRAC = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_CNT_W  = 5;

   localparam logic [TIME_W-1:0]  TIME_MAX       = '1;
   localparam logic [SPEED_W-1:0] SPEED_RESET    = 16'h1000;
   localparam logic [TIME_W-1:0]  RAMP_LEN_RESET = 32'h0001_0000;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_LENGTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_OUT_FLOOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PING_PONG      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_RESET     = 3'd4;

   // Operation carried by a request beat.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef struct packed {
      logic paused;
      logic at_end;
      logic ramp_in;
      logic ramp_out;
      logic reverse;
      logic hold;
      logic wrapped;
   } play_flags_type;

endpackage

/* design/playback_position_advance.sv */
// ----------------------------------------------------------------------------
// Playback position advance
// Moves a Q16.16 playback position by a speed- and ramp-scaled time step per
// tick, with hold, pause, loop counting, wrap and ping-pong at range edges.
// ----------------------------------------------------------------------------
// Sequence: a load goes from accept straight to publishing its result; a
// tick passes the speed multiply, scale, ramp and move states, and a tick
// inside a ramp may add the ramp multiply and the 32 one-bit restoring divider steps.
// Throughput: one item at a time; the next beat is taken once the result
// has been moved into the output register.
// Reset: synchronous; clears the playback state and loads register defaults.
module playback_position_advance import ppa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [TIME_W-1:0]        req_step_time,
   input  logic [TIME_W-1:0]        req_range_start,
   input  logic [TIME_W-1:0]        req_range_end,
   input  logic [TIME_W-1:0]        req_load_position,
   input  logic signed [LOOP_W-1:0] req_load_loops,
   input  logic                     req_load_reverse,
   input  logic                     req_load_ramp_in,
   input  logic                     req_load_ramp_out,
   input  logic [TIME_W-1:0]        req_load_ramp_progress,
   input  logic [TIME_W-1:0]        req_load_hold_time,
   input  logic                     req_load_paused,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [TIME_W-1:0]        rsp_position,
   output logic signed [LOOP_W-1:0] rsp_loops_left,
   output logic                     rsp_reverse,
   output logic                     rsp_paused,
   output logic                     rsp_at_end,
   output logic                     rsp_wrapped,
   output logic                     rsp_ramp_in_active,
   output logic                     rsp_ramp_out_active,
   output logic                     rsp_hold_active,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [TIME_W-1:0]        csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_SPEED, S_SCALE, S_RAMP, S_MUL_RAMP, S_DIV_INIT, S_DIV, S_MOVE,
      S_PUBLISH
   } state_type;

   state_type state_ff, state_in;

   // Configuration.
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [TIME_W-1:0]  len_ff, len_in;
   logic [TIME_W-1:0]  floor_ff, floor_in;
   logic               ping_ff, ping_in;
   logic               auto_ff, auto_in;

   // Playback state.
   logic [TIME_W-1:0]  pos_ff, pos_in;
   logic [LOOP_W-1:0]  loops_ff, loops_in;
   play_flags_type     flags_ff, flags_in;
   logic [TIME_W-1:0]  prog_ff, prog_in;
   logic [TIME_W-1:0]  hold_rem_ff, hold_rem_in;

   // Per-tick working registers.
   logic [TIME_W-1:0]    t_ff, t_in;
   logic [TIME_W-1:0]    start_ff, start_in;
   logic [TIME_W-1:0]    end_ff, end_in;
   logic [TIME_W-1:0]    s_ff, s_in;
   logic [2*TIME_W-1:0]  prod_ff, prod_in;
   logic [TIME_W-1:0]    step_ff, step_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]        out_pos_ff, out_pos_in;
   logic [LOOP_W-1:0]        out_loops_ff, out_loops_in;
   play_flags_type           out_flags_ff, out_flags_in;

   // Shared multiplier and divider step.
   logic [TIME_W-1:0]   mul_a, mul_b;
   logic [2*TIME_W-1:0] mul_p;
   logic [TIME_W-1:0]   div_len;
   logic [TIME_W:0]     div_trial;
   logic                div_bit;

   assign mul_a = (state_ff == S_SPEED) ? t_ff : s_ff;
   assign mul_b = (state_ff == S_SPEED) ? {{(TIME_W-SPEED_W){1'b0}}, speed_ff} : prog_ff;
   assign mul_p = mul_a * mul_b;

   assign div_len   = (len_ff == '0) ? {{(TIME_W-1){1'b0}}, 1'b1} : len_ff;
   assign div_trial = {rem_ff, step_ff[TIME_W-1]};
   assign div_bit   = (div_trial >= {1'b0, div_len});

   always_comb begin
      logic              accept;
      logic              out_free;
      logic [TIME_W:0]   sum33;
      logic [TIME_W-1:0] p_val;
      logic [TIME_W-1:0] diff;
      logic [LOOP_W-1:0] loops_dec;
      logic              edge_hit;

      state_in     = state_ff;
      speed_in     = speed_ff;
      len_in       = len_ff;
      floor_in     = floor_ff;
      ping_in      = ping_ff;
      auto_in      = auto_ff;
      pos_in       = pos_ff;
      loops_in     = loops_ff;
      flags_in     = flags_ff;
      prog_in      = prog_ff;
      hold_rem_in  = hold_rem_ff;
      t_in         = t_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      s_in         = s_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_pos_in   = out_pos_ff;
      out_loops_in = out_loops_ff;
      out_flags_in = out_flags_ff;
      sum33        = '0;
      p_val        = '0;
      diff         = pos_ff - step_ff;
      loops_dec    = ($signed(loops_ff) > 0) ? loops_ff - 1'b1 : loops_ff;
      edge_hit     = 1'b0;

      accept       = req_valid && (state_ff == S_IDLE);
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  pos_in           = req_load_position;
                  loops_in         = req_load_loops;
                  prog_in          = req_load_ramp_progress;
                  hold_rem_in      = req_load_hold_time;
                  flags_in         = '0;
                  flags_in.reverse = req_load_reverse;
                  flags_in.ramp_in = req_load_ramp_in;
                  flags_in.ramp_out = req_load_ramp_out;
                  flags_in.hold    = (req_load_hold_time != '0);
                  flags_in.paused  = req_load_paused;
                  state_in         = S_PUBLISH;
               end else begin
                  t_in             = req_step_time;
                  start_in         = req_range_start;
                  end_in           = req_range_end;
                  flags_in.wrapped = 1'b0;
                  flags_in.at_end  = 1'b0;
                  if (flags_ff.hold) begin
                     if (req_step_time >= hold_rem_ff) begin
                        hold_rem_in     = '0;
                        flags_in.hold   = 1'b0;
                        flags_in.paused = 1'b0;
                     end else begin
                        hold_rem_in = hold_rem_ff - req_step_time;
                     end
                  end
                  state_in = S_SPEED;
               end
            end
         end
         S_SPEED: begin
            prod_in  = mul_p;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            // The speed product is at most 48 bits; keep the integer part.
            if (prod_ff[2*TIME_W-1:TIME_W+SPEED_FRAC] != '0) begin
               s_in = TIME_MAX;
            end else begin
               s_in = prod_ff[TIME_W+SPEED_FRAC-1:SPEED_FRAC];
            end
            state_in = S_RAMP;
         end
         S_RAMP: begin
            if (flags_ff.ramp_in) begin
               sum33 = {1'b0, prog_ff} + {1'b0, s_ff};
               p_val = sum33[TIME_W] ? TIME_MAX : sum33[TIME_W-1:0];
               if (p_val >= len_ff) begin
                  flags_in.ramp_in = 1'b0;
                  prog_in          = '0;
                  step_in          = s_ff;
                  state_in         = S_MOVE;
               end else begin
                  prog_in  = p_val;
                  state_in = S_MUL_RAMP;
               end
            end else if (flags_ff.ramp_out) begin
               p_val = (s_ff > prog_ff) ? floor_ff : prog_ff - s_ff;
               if (p_val < floor_ff) begin
                  p_val = floor_ff;
               end
               if (p_val == '0) begin
                  flags_in.ramp_out = 1'b0;
                  flags_in.paused   = 1'b1;
                  prog_in           = '0;
                  step_in           = s_ff;
                  state_in          = S_MOVE;
               end else begin
                  prog_in  = p_val;
                  state_in = S_MUL_RAMP;
               end
            end else begin
               step_in  = s_ff;
               state_in = S_MOVE;
            end
         end
         S_MUL_RAMP: begin
            prod_in  = mul_p;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            // A high half at or above the divisor means the quotient
            // does not fit in 32 bits, so it saturates.
            if (prod_ff[2*TIME_W-1:TIME_W] >= div_len) begin
               step_in  = TIME_MAX;
               state_in = S_MOVE;
            end else begin
               rem_in   = prod_ff[2*TIME_W-1:TIME_W];
               step_in  = prod_ff[TIME_W-1:0];
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // The low dividend bits shift out of step_ff as quotient bits
            // shift in.
            if (div_bit) begin
               rem_in = TIME_W'(div_trial - {1'b0, div_len});
            end else begin
               rem_in = div_trial[TIME_W-1:0];
            end
            step_in = {step_ff[TIME_W-2:0], div_bit};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(TIME_W-1)) begin
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            state_in = S_PUBLISH;
            if (!flags_ff.paused) begin
               if (flags_ff.reverse) begin
                  edge_hit = (step_ff > pos_ff) || (diff < start_ff);
                  if (!edge_hit) begin
                     pos_in = diff;
                  end else begin
                     loops_in = loops_dec;
                     if ((loops_dec == '0) || ping_ff) begin
                        pos_in          = start_ff;
                        flags_in.at_end = 1'b1;
                        if (loops_dec != '0) begin
                           flags_in.reverse = 1'b0;
                        end
                     end else begin
                        pos_in           = end_ff;
                        flags_in.wrapped = 1'b1;
                     end
                  end
               end else begin
                  sum33    = {1'b0, pos_ff} + {1'b0, step_ff};
                  edge_hit = (sum33 > {1'b0, end_ff});
                  if (!edge_hit) begin
                     pos_in = sum33[TIME_W-1:0];
                  end else begin
                     loops_in = loops_dec;
                     if (loops_dec == '0) begin
                        if (auto_ff) begin
                           pos_in          = '0;
                           flags_in.paused = 1'b0;
                           flags_in.at_end = 1'b0;
                           auto_in         = 1'b0;
                           loops_in        = LOOP_W'(1);
                        end else begin
                           pos_in          = end_ff;
                           flags_in.at_end = 1'b1;
                        end
                     end else if (ping_ff) begin
                        pos_in           = end_ff;
                        flags_in.reverse = 1'b1;
                        flags_in.at_end  = 1'b1;
                     end else begin
                        pos_in           = start_ff;
                        flags_in.wrapped = 1'b1;
                     end
                  end
               end
            end
         end
         S_PUBLISH: begin
            if (out_free) begin
               out_pos_in   = pos_ff;
               out_loops_in = loops_ff;
               out_flags_in = flags_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPEED_SCALE:    speed_in = csr_wdata[SPEED_W-1:0];
            CSR_RAMP_LENGTH:    len_in   = csr_wdata;
            CSR_RAMP_OUT_FLOOR: floor_in = csr_wdata;
            CSR_PING_PONG:      ping_in  = csr_wdata[0];
            CSR_AUTO_RESET:     auto_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= SPEED_RESET;
         len_ff       <= RAMP_LEN_RESET;
         floor_ff     <= '0;
         ping_ff      <= 1'b0;
         auto_ff      <= 1'b0;
         pos_ff       <= '0;
         loops_ff     <= '0;
         flags_ff     <= '0;
         prog_ff      <= '0;
         hold_rem_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         speed_ff     <= speed_in;
         len_ff       <= len_in;
         floor_ff     <= floor_in;
         ping_ff      <= ping_in;
         auto_ff      <= auto_in;
         pos_ff       <= pos_in;
         loops_ff     <= loops_in;
         flags_ff     <= flags_in;
         prog_ff      <= prog_in;
         hold_rem_ff  <= hold_rem_in;
      end
      t_ff         <= t_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      s_ff         <= s_in;
      prod_ff      <= prod_in;
      step_ff      <= step_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      out_pos_ff   <= out_pos_in;
      out_loops_ff <= out_loops_in;
      out_flags_ff <= out_flags_in;
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position        = out_pos_ff;
   assign rsp_loops_left      = out_loops_ff;
   assign rsp_reverse         = out_flags_ff.reverse;
   assign rsp_paused          = out_flags_ff.paused;
   assign rsp_at_end          = out_flags_ff.at_end;
   assign rsp_wrapped         = out_flags_ff.wrapped;
   assign rsp_ramp_in_active  = out_flags_ff.ramp_in;
   assign rsp_ramp_out_active = out_flags_ff.ramp_out;
   assign rsp_hold_active     = out_flags_ff.hold;

endmodule
